// ===== src/query_string_percent_decoder_defines.svh =====
// Assertion macros for the query string percent decoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef QUERY_STRING_PERCENT_DECODER_DEFINES_SVH
`define QUERY_STRING_PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define QSPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QSPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QSPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QSPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/qspd_pkg.sv =====
// Shared types, character constants and the hex digit decode for the decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package qspd_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_SEP  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    // All results caused by one request, in order; slots at or above count are unused.
    typedef struct packed {
        item_t [MAX_RESULTS-1:0] items;
        logic  [CNT_W-1:0]       count;
    } group_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== src/qspd_decode.sv =====
// Escape state and per-request result builder.
// Depends on qspd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "query_string_percent_decoder_defines.svh"

module qspd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                load,
    output qspd_pkg::group_t    group
);

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX1 = 2'd2
    } phase_t;

    localparam int NCAND = 6;

    phase_t     phase_reg,  phase_next;
    logic [7:0] fchar_reg,  fchar_next;
    logic [3:0] fval_reg,   fval_next;

    phase_t                     phase_after;
    logic [7:0]                 fchar_after;
    logic [3:0]                 fval_after;
    logic                       run_plain;
    qspd_pkg::hex_t             hex;
    qspd_pkg::item_t            cand [NCAND];
    logic [NCAND-1:0]           cv;
    logic [qspd_pkg::CNT_W-1:0] pos;

    assign hex = qspd_pkg::hex_decode(in_byte);

    always_comb
    begin
        phase_after = PH_NONE;
        fchar_after = fchar_reg;
        fval_after  = fval_reg;
        run_plain   = 1'b0;
        cv          = '0;
        for (int i = 0; i < NCAND; i++) begin
            cand[i].kind = qspd_pkg::KIND_DATA;
            cand[i].data = 8'd0;
        end

        // pending escape prefix
        unique case (phase_reg)
            PH_PCT:
            begin
                if (hex.ok) begin
                    phase_after = PH_HEX1;
                    fchar_after = in_byte;
                    fval_after  = hex.value;
                end
                else begin
                    cv[0]        = 1'b1;
                    cand[0].data = qspd_pkg::CHAR_PCT;
                    run_plain    = 1'b1;
                end
            end
            PH_HEX1:
            begin
                if (hex.ok) begin
                    cv[0]        = 1'b1;
                    cand[0].data = {fval_reg, hex.value};
                end
                else begin
                    cv[0]        = 1'b1;
                    cand[0].data = qspd_pkg::CHAR_PCT;
                    cv[1]        = 1'b1;
                    cand[1].data = fchar_reg;
                    run_plain    = 1'b1;
                end
            end
            default:
            begin
                run_plain = 1'b1;
            end
        endcase

        // byte handled with no escape pending
        if (run_plain) begin
            if (in_byte == qspd_pkg::CHAR_AMP) begin
                cv[2]        = 1'b1;
                cand[2].kind = qspd_pkg::KIND_SEP;
            end
            else if (in_byte == qspd_pkg::CHAR_PCT) begin
                phase_after = PH_PCT;
            end
            else if (in_byte == qspd_pkg::CHAR_PLUS) begin
                cv[2]        = 1'b1;
                cand[2].data = qspd_pkg::CHAR_SPACE;
            end
            else begin
                cv[2]        = 1'b1;
                cand[2].data = in_byte;
            end
        end

        // end of string: flush open escape, then end marker
        if (in_last) begin
            if (phase_after == PH_PCT || phase_after == PH_HEX1) begin
                cv[3]        = 1'b1;
                cand[3].data = qspd_pkg::CHAR_PCT;
            end
            if (phase_after == PH_HEX1) begin
                cv[4]        = 1'b1;
                cand[4].data = fchar_after;
            end
            cv[5]        = 1'b1;
            cand[5].kind = qspd_pkg::KIND_END;
        end

        // pack valid candidates into consecutive slots
        pos         = '0;
        group.items = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cv[i] && pos < qspd_pkg::CNT_W'(qspd_pkg::MAX_RESULTS)) begin
                group.items[pos[qspd_pkg::IDX_W-1:0]] = cand[i];
                pos = pos + 1'b1;
            end
        end
        group.count = pos;

        if (in_last) begin
            phase_next = PH_NONE;
            fchar_next = 8'd0;
            fval_next  = 4'd0;
        end
        else begin
            phase_next = phase_after;
            fchar_next = fchar_after;
            fval_next  = fval_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_NONE;
            fchar_reg <= 8'd0;
            fval_reg  <= 4'd0;
        end
        else if (load) begin
            phase_reg <= phase_next;
            fchar_reg <= fchar_next;
            fval_reg  <= fval_next;
        end
    end

    `QSPD_ASSERT_NXT(a_last_clears, clk, rst_n, load && in_last, phase_reg == PH_NONE, "escape state not cleared after last byte")
    `QSPD_ASSERT_IMP(a_last_ends, clk, rst_n, load && in_last, group.count != '0, "last byte produced no end marker")
    `QSPD_ASSERT_NXT(a_pct_pends, clk, rst_n, load && !in_last && phase_reg == PH_NONE && in_byte == qspd_pkg::CHAR_PCT, phase_reg == PH_PCT, "percent sign did not open an escape")

endmodule

// ===== src/qspd_outbuf.sv =====
// Result register: holds one request's result group and hands items out one per cycle while out_ready is high.
// Depends on qspd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "query_string_percent_decoder_defines.svh"

module qspd_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  qspd_pkg::group_t    group,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    qspd_pkg::item_t [qspd_pkg::MAX_RESULTS-1:0] items_reg;
    logic [qspd_pkg::CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [qspd_pkg::IDX_W-1:0]                  idx_reg, idx_next;

    qspd_pkg::item_t cur;
    logic            is_last;
    logic            fire;

    assign cur       = items_reg[idx_reg];
    assign is_last   = (qspd_pkg::CNT_W'(idx_reg) + qspd_pkg::CNT_W'(1)) == cnt_reg;
    assign out_valid = cnt_reg != '0;
    assign fire      = out_valid && out_ready;
    assign free      = !out_valid || (out_ready && is_last);

    assign out_kind = cur.kind;
    assign out_byte = cur.data;
    assign out_last = is_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = group.count;
            idx_next = '0;
        end
        else if (fire && is_last) begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (fire) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            items_reg <= group.items;
        end
    end

    `QSPD_ASSERT_IMP(a_load_free, clk, rst_n, load, free, "group loaded over undelivered results")
    `QSPD_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid, qspd_pkg::CNT_W'(idx_reg) < cnt_reg, "result index beyond group count")
    `QSPD_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= qspd_pkg::CNT_W'(qspd_pkg::MAX_RESULTS), "group count above maximum")

endmodule

// ===== src/query_string_percent_decoder.sv =====
// Top level of the query string percent decoder: input register and wiring.
// Depends on qspd_pkg, qspd_decode and qspd_outbuf.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+--------------------------
//  in      | in_valid / in_ready             | sink      | in_byte[7:0], in_last
//  out     | out_valid / out_ready           | source    | out_kind[1:0], out_byte[7:0],
//          |                                 |           | out_last
//
// Each request is registered, then decoded combinationally into a group of 0 to 4 results
// that loads the result register while the previous group drains.
// Throughput: one request per cycle while out_ready is high and each yields at most one
// result; a request with several results holds the result register until all are taken,
// and a zero-result request does not hold it.
// Reset clears the escape state and empties both registers; payload is not reset.
// A stalled output holds the result register, then the input register, then in_ready.
`timescale 1ns / 1ps

module query_string_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic       vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic             buf_free;
    logic             move;
    qspd_pkg::group_t group;

    // request moves from the input register into the decoder/result register
    assign move     = vld_reg && buf_free;
    assign in_ready = !vld_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready) begin
            vld_reg <= 1'b1;
        end
        else if (move) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // escape state machine and result group builder
    qspd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (byte_reg),
        .in_last (last_reg),
        .load    (move),
        .group   (group)
    );

    // result register, one item out per cycle while out_ready is high
    qspd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .group     (group),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ===== tb/query_string_percent_decoder_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for query_string_percent_decoder: a directed table, then random
// query strings, every result compared against typed expectations or an in-bench decoder model.
// Depends on qspd_pkg (kind codes, character constants) and the decoder RTL.

module query_string_percent_decoder_tb;

    localparam int RANDOM_REQS  = 154;
    localparam int HOLD_AT      = 40;    // random request index that triggers the long hold
    localparam int HOLD_CYCLES  = 80;    // long enough to back the block up into in_ready
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all before giving up
    localparam int DRAIN_CYCLES = 8;     // leave room for stray results
    localparam int MAX_REPORTS  = 10;
    localparam int N_ROWS       = 26;

    // Short local names for the package codes and characters.
    localparam qspd_pkg::kind_t K_DATA = qspd_pkg::KIND_DATA;
    localparam qspd_pkg::kind_t K_SEP  = qspd_pkg::KIND_SEP;
    localparam qspd_pkg::kind_t K_END  = qspd_pkg::KIND_END;
    localparam logic [7:0] C_AMP   = qspd_pkg::CHAR_AMP;
    localparam logic [7:0] C_PCT   = qspd_pkg::CHAR_PCT;
    localparam logic [7:0] C_PLUS  = qspd_pkg::CHAR_PLUS;
    localparam logic [7:0] C_SPACE = qspd_pkg::CHAR_SPACE;

    // Escape tracking phases of the model.
    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    typedef struct packed {
        qspd_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
    } result_t;

    // One directed request. Where typed is set, n results (k0/d0, then k1/d1) are
    // written in by hand; otherwise the model supplies the expectation.
    typedef struct packed {
        logic [7:0]      b;
        logic            last;
        logic            typed;
        logic [1:0]      n;
        qspd_pkg::kind_t k0;
        logic [7:0]      d0;
        qspd_pkg::kind_t k1;
        logic [7:0]      d1;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    // Model state
    logic [1:0] esc_phase;
    logic [7:0] held_char;
    logic [3:0] held_val;
    result_t    step_res[$];          // results of the request being modeled
    result_t    pending_results[$];   // everything still owed by the block

    row_t       dir_tab [N_ROWS];
    logic [8:0] token_bytes[$];       // {last, byte} of the random string being sent

    bit calm;                         // no idling on either side while set
    bit hold_req;                     // asks the receiver for one long hold-off

    int n_requests;
    int n_results;
    int n_escapes;
    int n_malformed;
    int n_strings;
    int n_holds;
    int n_errors;

    query_string_percent_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // {ok, nibble} for a character: only 0-9, a-f and A-F count as hex.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h57)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h37)};
        end
        return 5'd0;
    endfunction

    task automatic add_result(input qspd_pkg::kind_t k, input logic [7:0] d);
        step_res.push_back('{k, d, 1'b0});
    endtask

    // A byte with no escape pending.
    task automatic decode_plain(input logic [7:0] c);
        if (c == C_AMP)
        begin
            add_result(K_SEP, 8'h00);
        end
        else if (c == C_PCT)
        begin
            esc_phase = ESC_PCT;
        end
        else if (c == C_PLUS)
        begin
            add_result(K_DATA, C_SPACE);
        end
        else
        begin
            add_result(K_DATA, c);
        end
    endtask

    // Fills step_res with what one request should produce and advances the state.
    task automatic decode_request(input logic [7:0] c, input logic l);
        logic [4:0] h;
        step_res.delete();
        h = hex_nibble(c);
        case (esc_phase)
            ESC_PCT:
            begin
                if (h[4])
                begin
                    held_char = c;
                    held_val  = h[3:0];
                    esc_phase = ESC_DIGIT;
                end
                else
                begin
                    // Broken after the percent: replay it, then take the byte fresh.
                    add_result(K_DATA, C_PCT);
                    esc_phase = ESC_IDLE;
                    n_malformed++;
                    decode_plain(c);
                end
            end
            ESC_DIGIT:
            begin
                esc_phase = ESC_IDLE;
                if (h[4])
                begin
                    add_result(K_DATA, {held_val, h[3:0]});
                    n_escapes++;
                end
                else
                begin
                    add_result(K_DATA, C_PCT);
                    add_result(K_DATA, held_char);
                    n_malformed++;
                    decode_plain(c);
                end
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                decode_plain(c);
            end
        endcase
        if (l)
        begin
            // Flush a dangling escape literally, then close the string.
            if (esc_phase == ESC_PCT)
            begin
                add_result(K_DATA, C_PCT);
            end
            else if (esc_phase == ESC_DIGIT)
            begin
                add_result(K_DATA, C_PCT);
                add_result(K_DATA, held_char);
            end
            add_result(K_END, 8'h00);
            esc_phase = ESC_IDLE;
            held_char = 8'h00;
            held_val  = 4'h0;
            n_strings++;
        end
        if (step_res.size() > 0)
        begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Idling and random characters
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int idle_gap(input bit quiet);
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        if ($urandom_range(1) == 0)
        begin
            return 8'h57 + 8'(v);    // lower case
        end
        return 8'h37 + 8'(v);        // upper case
    endfunction

    function automatic logic [7:0] rand_non_hex_char();
        logic [7:0] c;
        logic [4:0] h;
        c = 8'($urandom_range(255));
        h = hex_nibble(c);
        while (h[4])
        begin
            c = 8'($urandom_range(255));
            h = hex_nibble(c);
        end
        return c;
    endfunction

    // Appends one token of a query string: mostly well-formed pieces, some broken
    // escapes and raw noise. One token in ten closes the string at random, as does every cut-short escape.
    task automatic build_token();
        int  r;
        bit  close;
        r     = $urandom_range(99);
        close = ($urandom_range(9) == 0);
        if (r < 30)
        begin
            token_bytes.push_back({1'b0, 8'($urandom_range(8'h21, 8'h7E))});
        end
        else if (r < 40)
        begin
            token_bytes.push_back({1'b0, C_PLUS});
        end
        else if (r < 50)
        begin
            token_bytes.push_back({1'b0, C_AMP});
        end
        else if (r < 75)
        begin
            token_bytes.push_back({1'b0, C_PCT});
            token_bytes.push_back({1'b0, rand_hex_char()});
            token_bytes.push_back({1'b0, rand_hex_char()});
        end
        else if (r < 85)
        begin
            // Escape broken after the percent or after the first digit.
            token_bytes.push_back({1'b0, C_PCT});
            if ($urandom_range(1) == 0)
            begin
                token_bytes.push_back({1'b0, rand_hex_char()});
            end
            token_bytes.push_back({1'b0, rand_non_hex_char()});
        end
        else if (r < 90)
        begin
            // Escape cut short by the end of the string.
            token_bytes.push_back({1'b0, C_PCT});
            if ($urandom_range(1) == 0)
            begin
                token_bytes.push_back({1'b0, rand_hex_char()});
            end
            close = 1'b1;
        end
        else
        begin
            token_bytes.push_back({1'b0, 8'($urandom_range(255))});
        end
        if (close)
        begin
            token_bytes[token_bytes.size() - 1][8] = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Request side: payload changes at the falling edge, acceptance is seen
    // at the rising edge. Returns at the falling edge after acceptance.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [7:0] b, input logic l);
        int g;
        g = idle_gap(calm);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n_requests++;
        @(negedge clk);
    endtask

    task automatic queue_model_results();
        foreach (step_res[k])
        begin
            pending_results.push_back(step_res[k]);
        end
    endtask

    initial
    begin
        // Directed table: plain extremes first (expectations typed in), then every
        // escape path, hex boundaries and the end-of-string flushes.
        dir_tab = '{
            '{8'h61,  1'b0, 1'b1, 2'd1, K_DATA, 8'h61,   K_DATA, 8'h00}, // a
            '{8'h00,  1'b0, 1'b1, 2'd1, K_DATA, 8'h00,   K_DATA, 8'h00}, // NUL is data
            '{8'hFF,  1'b0, 1'b1, 2'd1, K_DATA, 8'hFF,   K_DATA, 8'h00},
            '{C_PLUS, 1'b0, 1'b1, 2'd1, K_DATA, C_SPACE, K_DATA, 8'h00},
            '{C_AMP,  1'b0, 1'b1, 2'd1, K_SEP,  8'h00,   K_DATA, 8'h00},
            '{C_PCT,  1'b0, 1'b1, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // silent
            '{8'h34,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // 4
            '{8'h31,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // 1
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h66,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // f
            '{8'h46,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // F
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h47,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // G
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h39,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // 9
            '{8'h3A,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // colon
            '{C_PCT,  1'b1, 1'b1, 2'd2, K_DATA, C_PCT,   K_END,  8'h00},
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h61,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // a
            '{C_PLUS, 1'b1, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // 4 out
            '{C_AMP,  1'b1, 1'b1, 2'd2, K_SEP,  8'h00,   K_END,  8'h00},
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h40,  1'b1, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}, // @
            '{C_PCT,  1'b0, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00},
            '{8'h2F,  1'b1, 1'b0, 2'd0, K_DATA, 8'h00,   K_DATA, 8'h00}  // slash
        };

        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        esc_phase = ESC_IDLE;
        held_char = 8'h00;
        held_val  = 4'h0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            send_request(dir_tab[i].b, dir_tab[i].last);
            decode_request(dir_tab[i].b, dir_tab[i].last);
            if (dir_tab[i].typed)
            begin
                if (dir_tab[i].n != 2'd0)
                begin
                    pending_results.push_back('{dir_tab[i].k0, dir_tab[i].d0,
                                                dir_tab[i].n == 2'd1});
                end
                if (dir_tab[i].n == 2'd2)
                begin
                    pending_results.push_back('{dir_tab[i].k1, dir_tab[i].d1, 1'b1});
                end
            end
            else
            begin
                queue_model_results();
            end
        end

        // Random strings. A window in the middle runs with no idling on either side.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            logic [8:0] t;
            if (token_bytes.size() == 0)
            begin
                build_token();
            end
            t    = token_bytes.pop_front();
            calm = (i >= 100 && i < 140);
            if (i == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            send_request(t[7:0], t[8]);
            decode_request(t[7:0], t[8]);
            queue_model_results();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Requests that owe nothing may still be in flight; give them time to misbehave.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d requests, %0d results, %0d strings closed, %0d escapes decoded,",
                 n_requests, n_results, n_strings, n_escapes);
        $display("     %0d malformed escapes replayed, %0d long output hold(s), %0d mismatches",
                 n_malformed, n_holds, n_errors);
        if (n_errors == 0)
        begin
            $display("query_string_percent_decoder verification clean");
        end
        else
        begin
            $display("query_string_percent_decoder verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready changes at the falling edge. One long hold-off on
    // request, otherwise random stalls.
    // ------------------------------------------------------------------
    initial
    begin
        int g;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req && n_holds == 0)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                n_holds++;
            end
            else
            begin
                g = idle_gap(calm);
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted result against the oldest one owed.
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("result with nothing owed: kind=%0d byte=%02h last=%0d",
                                     out_kind, out_byte, out_last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_kind !== want.kind || out_byte !== want.data
                    || out_last !== want.last)
                begin
                    flag_error($sformatf(
                        "expected kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                        want.kind, want.data, want.last, out_kind, out_byte, out_last));
                end
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("watchdog: no request or result moved for %0d cycles, %0d results owed",
                 IDLE_LIMIT, pending_results.size());
        $display("query_string_percent_decoder verification failed");
        $finish;
    end

endmodule
